// ===== rtl/vapc_pkg.sv =====
// Package for the valve actuator position controller.
// Holds the port words, the internal command word, codes and arithmetic constants.
// No dependencies.
`default_nettype none

package vapc_pkg;

    // Field widths
    localparam int POS_W      = 16;
    localparam int ADC_W      = 12;
    localparam int PCT_W      = 7;
    localparam int DEB_W      = 8;
    localparam int ROUNDS_W   = 2;
    localparam int SUM_W      = POS_W + 1;
    localparam int CFG_DATA_W = 12;

    // full_open * percent, and floor(x / 100) as (x * RECIP_M) >> RECIP_SHIFT.
    // The reciprocal error stays below one unit for every x below 2**PROD_W.
    localparam int PROD_W      = POS_W + PCT_W;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_M = 24'd10737419;
    localparam int RMUL_W      = PROD_W + RECIP_W;
    localparam int QUOT_W      = RMUL_W - RECIP_SHIFT;

    // Queue depths
    localparam int MIDQ_DEPTH = 2;
    localparam int MIDQ_PTR_W = $clog2(MIDQ_DEPTH);
    localparam int MIDQ_CNT_W = $clog2(MIDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [ADC_W-1:0] THRESHOLD_RST = 12'd2025;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 8'd20;

    // Number of end-stop closings in one calibration
    localparam logic [ROUNDS_W-1:0] CALIB_CLOSE_ROUNDS = 2'd3;

    // Motor drive codes
    localparam logic [1:0] DRIVE_STOP = 2'd0;
    localparam logic [1:0] DRIVE_FWD  = 2'd1;
    localparam logic [1:0] DRIVE_BACK = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ADC    = 2'd1,
        REQ_CALIB  = 2'd2,
        REQ_SETPOS = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CALIB = 2'd1,
        MODE_SEEK  = 2'd2
    } t_mode;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_DEBOUNCE  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ADC_W-1:0] adc_value;
        logic [PCT_W-1:0] percent;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       motor_drive;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] max_position;
        logic             busy_res;
        logic             end_stop;
        logic             calib_done;
    } t_out_word;

    // Classified event passed from front to back
    typedef struct packed {
        t_req             req;
        logic             hit;
        logic [PCT_W-1:0] percent;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/vapc_queue.sv =====
// Two-entry command queue between the front and the back.
// Depends on vapc_pkg (t_cmd, depth constants).
`default_nettype none

module vapc_queue import vapc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_word,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_word,
    input  wire logic i_pop
);

    t_cmd                  r_mem [MIDQ_DEPTH];
    logic [MIDQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [MIDQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [MIDQ_CNT_W-1:0] r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == MIDQ_CNT_W'(MIDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == MIDQ_PTR_W'(MIDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == MIDQ_PTR_W'(MIDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vapc_front.sv =====
// Front end: configuration registers and classification of incoming words.
// Depends on vapc_pkg; feeds vapc_queue.
`default_nettype none

module vapc_front import vapc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  wire logic                  i_push,
    input  wire t_in_word              i_word,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_cmd                       o_q_word,
    output logic [DEB_W-1:0]           o_debounce
);

    logic [ADC_W-1:0] r_threshold;
    logic [DEB_W-1:0] r_debounce;
    t_req             req;

    assign o_cfg_ready = 1'b1;
    assign o_debounce  = r_debounce;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_debounce  <= DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[ADC_W-1:0];
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[DEB_W-1:0];
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    // Classify: decode the event and judge the end-stop sample now
    assign req               = t_req'(i_word.req_type);
    assign o_q_push          = i_push && !i_q_full;
    assign o_q_word.req      = req;
    assign o_q_word.hit      = (req == REQ_ADC) && (i_word.adc_value < r_threshold);
    assign o_q_word.percent  = i_word.percent;

endmodule

`default_nettype wire

// ===== rtl/vapc_back.sv =====
// Back end: target product, controller state update and result buffer.
// Depends on vapc_pkg; drains vapc_queue.
`default_nettype none

module vapc_back import vapc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_cmd             i_q_word,
    output logic                  o_q_pop,
    input  wire logic [DEB_W-1:0] i_debounce,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output t_out_word             o_word
);

    // Execute stage
    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic [PROD_W-1:0] r_s1_prod;
    logic              s1_fire;
    logic              s1_load;
    logic [POS_W-1:0]  fo_fwd;
    logic [PROD_W-1:0] prod;

    // Controller state
    t_mode               r_mode, n_mode;
    logic                r_opening, n_opening;
    logic                r_running, n_running;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    r_full_open, n_full_open;
    logic [POS_W-1:0]    r_target, n_target;
    logic [DEB_W-1:0]    r_hit_count, n_hit_count;
    logic [ROUNDS_W-1:0] r_rounds, n_rounds;
    logic [SUM_W-1:0]    r_open_sum, n_open_sum;
    logic                done;

    logic [DEB_W-1:0]    hit_inc;
    logic [ROUNDS_W-1:0] rounds_inc;
    logic [RMUL_W-1:0]   rmul;
    logic [QUOT_W-1:0]   quot;
    logic [POS_W-1:0]    tgt_sat;
    t_out_word           res;

    // Result buffer
    t_out_word             r_ob_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_ob_wr, r_ob_rd;
    logic [OUTQ_CNT_W-1:0] r_ob_count;
    logic                  ob_pop;
    logic                  ob_room;

    assign ob_pop  = i_pop && !o_empty;
    assign ob_room = (r_ob_count != OUTQ_CNT_W'(OUTQ_DEPTH)) || ob_pop;
    assign s1_fire = r_s1_valid && ob_room;
    assign s1_load = i_q_valid && (!r_s1_valid || s1_fire);
    assign o_q_pop = s1_load;

    // Product for the entering word, with full_open forwarded from the word now leaving
    assign fo_fwd = s1_fire ? n_full_open : r_full_open;
    assign prod   = PROD_W'(fo_fwd) * PROD_W'(i_q_word.percent);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_cmd  <= i_q_word;
            r_s1_prod <= prod;
        end
    end

    // Divide by 100 through the reciprocal, then saturate to 16 bits
    assign rmul    = RMUL_W'(r_s1_prod) * RMUL_W'(RECIP_M);
    assign quot    = rmul[RMUL_W-1:RECIP_SHIFT];
    assign tgt_sat = (|quot[QUOT_W-1:POS_W]) ? '1 : quot[POS_W-1:0];

    assign hit_inc    = r_hit_count + 1'b1;
    assign rounds_inc = r_rounds + 1'b1;

    // Next state of the controller for the word in the execute stage
    always_comb begin
        n_mode      = r_mode;
        n_opening   = r_opening;
        n_running   = r_running;
        n_pos       = r_pos;
        n_full_open = r_full_open;
        n_target    = r_target;
        n_hit_count = r_hit_count;
        n_rounds    = r_rounds;
        n_open_sum  = r_open_sum;
        done        = 1'b0;
        if (r_s1_valid) begin
            unique case (r_s1_cmd.req)
                REQ_TICK: begin
                    if (r_running) begin
                        if (r_opening) begin
                            n_pos = r_pos + 1'b1;
                        end else if (r_pos != '0) begin
                            n_pos = r_pos - 1'b1;
                        end
                        if (r_mode == MODE_SEEK) begin
                            if (r_opening ? (n_pos >= r_target) : (n_pos <= r_target)) begin
                                n_running = 1'b0;
                                n_mode    = MODE_IDLE;
                            end
                        end
                    end
                end
                REQ_ADC: begin
                    if (r_s1_cmd.hit && r_mode == MODE_CALIB) begin
                        n_hit_count = hit_inc;
                        if (hit_inc >= i_debounce) begin
                            n_hit_count = '0;
                            if (r_opening) begin
                                n_open_sum = r_open_sum + SUM_W'(r_pos);
                                n_opening  = 1'b0;
                            end else begin
                                n_pos    = '0;
                                n_rounds = rounds_inc;
                                if (rounds_inc == CALIB_CLOSE_ROUNDS) begin
                                    n_running   = 1'b0;
                                    n_rounds    = '0;
                                    n_full_open = r_open_sum[SUM_W-1:1];
                                    n_mode      = MODE_IDLE;
                                    done        = 1'b1;
                                end else begin
                                    n_opening = 1'b1;
                                end
                            end
                        end
                    end
                end
                REQ_CALIB: begin
                    if (r_mode == MODE_IDLE) begin
                        n_mode      = MODE_CALIB;
                        n_opening   = 1'b0;
                        n_running   = 1'b1;
                        n_hit_count = '0;
                        n_rounds    = '0;
                        n_open_sum  = '0;
                    end
                end
                REQ_SETPOS: begin
                    if (r_mode == MODE_IDLE) begin
                        n_target = tgt_sat;
                        if (r_pos < tgt_sat) begin
                            n_opening = 1'b1;
                            n_running = 1'b1;
                            n_mode    = MODE_SEEK;
                        end else begin
                            n_opening = 1'b0;
                            if (r_pos > tgt_sat) begin
                                n_running = 1'b1;
                                n_mode    = MODE_SEEK;
                            end else begin
                                n_running = 1'b0;
                            end
                        end
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // Result word from the updated state
    always_comb begin
        res.motor_drive  = n_running ? (n_opening ? DRIVE_BACK : DRIVE_FWD) : DRIVE_STOP;
        res.position     = n_pos;
        res.max_position = n_full_open;
        res.busy_res     = (n_mode != MODE_IDLE);
        res.end_stop     = r_s1_cmd.hit;
        res.calib_done   = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_opening   <= 1'b1;
            r_running   <= 1'b0;
            r_pos       <= '0;
            r_full_open <= '0;
            r_target    <= '0;
            r_hit_count <= '0;
            r_rounds    <= '0;
            r_open_sum  <= '0;
        end else if (s1_fire) begin
            r_mode      <= n_mode;
            r_opening   <= n_opening;
            r_running   <= n_running;
            r_pos       <= n_pos;
            r_full_open <= n_full_open;
            r_target    <= n_target;
            r_hit_count <= n_hit_count;
            r_rounds    <= n_rounds;
            r_open_sum  <= n_open_sum;
        end
    end

    // Result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr    <= '0;
            r_ob_rd    <= '0;
            r_ob_count <= '0;
        end else begin
            if (s1_fire) begin
                r_ob_wr <= (r_ob_wr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_ob_wr + 1'b1;
            end
            if (ob_pop) begin
                r_ob_rd <= (r_ob_rd == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_ob_rd + 1'b1;
            end
            case ({s1_fire, ob_pop})
                2'b10:   r_ob_count <= r_ob_count + 1'b1;
                2'b01:   r_ob_count <= r_ob_count - 1'b1;
                default: r_ob_count <= r_ob_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_ob_mem[r_ob_wr] <= res;
        end
    end

    assign o_empty = (r_ob_count == '0);
    assign o_word  = r_ob_mem[r_ob_rd];

endmodule

`default_nettype wire

// ===== rtl/valve_actuator_position_controller.sv =====
// Top level of the valve actuator position controller.
// Depends on vapc_pkg, vapc_front, vapc_queue and vapc_back.
//
//   channel   direction  handshake                 word
//   input     in         push / full               i_in_word  (t_in_word)
//   result    out        empty / pop               o_out_word (t_out_word)
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word is taken per cycle while full is low, and one result is given per word. A
// result passes through the command queue, the execute stage and the result buffer.
// The execute stage updates the controller state for each word it passes on, so its
// state loop sets the rate. Synchronous reset; no clearing pass. With pop held low
// the result buffer, the execute stage and the command queue fill, then full rises.
`default_nettype none

module valve_actuator_position_controller import vapc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire t_in_word              i_in_word,
    output logic                       empty,
    input  wire logic                  pop,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             q_push;
    t_cmd             q_in;
    logic             q_valid;
    t_cmd             q_out;
    logic             q_pop;
    logic [DEB_W-1:0] debounce;

    vapc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_push      (push),
        .i_word      (i_in_word),
        .i_q_full    (full),
        .o_q_push    (q_push),
        .o_q_word    (q_in),
        .o_debounce  (debounce)
    );

    vapc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_word  (q_out),
        .i_pop   (q_pop)
    );

    vapc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_word   (q_out),
        .o_q_pop    (q_pop),
        .i_debounce (debounce),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_word     (o_out_word)
    );

    // The motor never runs while the controller is idle
    a_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_word.busy_res) |-> (o_out_word.motor_drive == DRIVE_STOP))
        else $error("motor running while idle");

    // Finishing calibration leaves the valve at the closed end stop
    a_calib_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.calib_done) |->
            (o_out_word.position == '0 && o_out_word.motor_drive == DRIVE_STOP))
        else $error("calibration done away from zero");

    // The command queue only fills through an accepted word
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without a push");

endmodule

`default_nettype wire

// ===== sim/valve_ctrl_checker.sv =====
// Scoreboard for the valve actuator position controller: watches the input, result
// and register channels, keeps its own copy of the controller state and compares.
// Depends on vapc_pkg.
`timescale 1ns / 1ps

module valve_ctrl_checker import vapc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic                  i_full,
    input  wire t_in_word              i_in_word,
    input  wire logic                  i_empty,
    input  wire logic                  i_pop,
    input  wire t_out_word             i_out_word,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_calibs
);

    // Register copies
    logic [ADC_W-1:0] cfg_thr;
    logic [DEB_W-1:0] cfg_deb;

    // Controller state copy
    t_mode               v_mode;
    logic                v_opening;
    logic                v_running;
    logic [POS_W-1:0]    v_pos;
    logic [POS_W-1:0]    v_full;
    logic [POS_W-1:0]    v_target;
    logic [DEB_W-1:0]    v_hits;
    logic [ROUNDS_W-1:0] v_rounds;
    logic [SUM_W-1:0]    v_sum;

    // Results owed by the controller, oldest first
    t_out_word awaited_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_calibs  = 0;
    end

    task automatic clear_valve_state();
        cfg_thr   = THRESHOLD_RST;
        cfg_deb   = DEBOUNCE_RST;
        v_mode    = MODE_IDLE;
        v_opening = 1'b1;
        v_running = 1'b0;
        v_pos     = '0;
        v_full    = '0;
        v_target  = '0;
        v_hits    = '0;
        v_rounds  = '0;
        v_sum     = '0;
    endtask

    // Apply one event to the state copy and build the result word it causes
    task automatic apply_valve_event(input t_in_word w, output t_out_word r);
        logic        hit;
        logic        done;
        logic        reached;
        logic [31:0] tgt;
        hit  = 1'b0;
        done = 1'b0;
        case (w.req_type)
            REQ_TICK: begin
                if (v_running) begin
                    // opening wraps, closing holds at zero
                    if (v_opening)
                        v_pos = v_pos + 1'b1;
                    else if (v_pos != '0)
                        v_pos = v_pos - 1'b1;
                    if (v_mode == MODE_SEEK) begin
                        reached = v_opening ? (v_pos >= v_target) : (v_pos <= v_target);
                        if (reached) begin
                            v_running = 1'b0;
                            v_mode    = MODE_IDLE;
                        end
                    end
                end
            end
            REQ_ADC: begin
                hit = (w.adc_value < cfg_thr);
                if (hit && v_mode == MODE_CALIB) begin
                    v_hits = v_hits + 1'b1;
                    // a debounce of zero ends the phase on the first hit
                    if (v_hits >= cfg_deb) begin
                        v_hits = '0;
                        if (v_opening) begin
                            v_sum     = v_sum + {1'b0, v_pos};
                            v_opening = 1'b0;
                        end else begin
                            v_pos    = '0;
                            v_rounds = v_rounds + 1'b1;
                            if (v_rounds == CALIB_CLOSE_ROUNDS) begin
                                v_running = 1'b0;
                                v_rounds  = '0;
                                v_full    = v_sum[SUM_W-1:1];
                                v_mode    = MODE_IDLE;
                                done      = 1'b1;
                            end else begin
                                v_opening = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                // commands only take effect while idle
                if (v_mode == MODE_IDLE) begin
                    if (w.req_type == REQ_CALIB) begin
                        v_mode    = MODE_CALIB;
                        v_opening = 1'b0;
                        v_running = 1'b1;
                        v_hits    = '0;
                        v_rounds  = '0;
                        v_sum     = '0;
                    end else begin
                        tgt = (32'(v_full) * 32'(w.percent)) / 32'd100;
                        if (tgt > 32'hFFFF)
                            tgt = 32'hFFFF;
                        v_target = tgt[POS_W-1:0];
                        if (v_pos < v_target) begin
                            v_opening = 1'b1;
                            v_running = 1'b1;
                            v_mode    = MODE_SEEK;
                        end else begin
                            v_opening = 1'b0;
                            if (v_pos > v_target) begin
                                v_running = 1'b1;
                                v_mode    = MODE_SEEK;
                            end else begin
                                v_running = 1'b0;
                            end
                        end
                    end
                end
            end
        endcase
        r.motor_drive  = v_running ? (v_opening ? DRIVE_BACK : DRIVE_FWD) : DRIVE_STOP;
        r.position     = v_pos;
        r.max_position = v_full;
        r.busy_res     = (v_mode != MODE_IDLE);
        r.end_stop     = hit;
        r.calib_done   = done;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            o_errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin : watch
        t_out_word want_w;
        if (!i_rst_n) begin
            clear_valve_state();
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_THRESHOLD)
                    cfg_thr = i_cfg_data[ADC_W-1:0];
                else
                    cfg_deb = i_cfg_data[DEB_W-1:0];
            end
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    o_errors++;
                    $display("%0t ns: result with none expected, expected none, actual %h",
                             $time, i_out_word);
                end else begin
                    want_w = awaited_results.pop_front();
                    check_field("motor_drive", want_w.motor_drive, i_out_word.motor_drive);
                    check_field("position", want_w.position, i_out_word.position);
                    check_field("max_position", want_w.max_position, i_out_word.max_position);
                    check_field("busy_res", want_w.busy_res, i_out_word.busy_res);
                    check_field("end_stop", want_w.end_stop, i_out_word.end_stop);
                    check_field("calib_done", want_w.calib_done, i_out_word.calib_done);
                    o_checked++;
                end
            end
            if (i_push && !i_full) begin
                apply_valve_event(i_in_word, want_w);
                awaited_results.push_back(want_w);
                if (want_w.calib_done)
                    o_calibs++;
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== sim/tb_valve_actuator_position_controller.sv =====
// Testbench top for the valve actuator position controller: clock, reset, stimulus
// and verdict. Depends on vapc_pkg, valve_ctrl_checker and the controller RTL.
`timescale 1ns / 1ps

module tb_valve_actuator_position_controller;
    import vapc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    t_in_word              in_word   = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int calibs;

    int cycles = 0;
    int tx_idle_pct = 21;
    int rx_idle_pct = 71;
    int cur_thr = THRESHOLD_RST;
    int cur_deb = DEBOUNCE_RST;
    int words_sent = 0;
    int busy_cmds_sent = 0;
    int cfg_writes = 0;

    valve_actuator_position_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    valve_ctrl_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_in_word   (in_word),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_calibs    (calibs)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random pop
    always @(posedge clk) begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one word; fields the event does not use get random content
    task automatic put_word(input t_req req, input int adc, input int pct);
        t_in_word w;
        w.req_type  = req;
        w.adc_value = (req == REQ_ADC) ? adc[ADC_W-1:0] : ADC_W'($urandom_range(0, 4095));
        w.percent   = (req == REQ_SETPOS) ? pct[PCT_W-1:0] : PCT_W'($urandom_range(0, 127));
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic int hit_value();
        if (cur_thr == 0)
            return 0;
        return $urandom_range(0, cur_thr - 1);
    endfunction

    function automatic int miss_value();
        return $urandom_range(cur_thr, 4095);
    endfunction

    // Stop sending and wait until every result is back
    task automatic go_quiet();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input int val);
        go_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_THRESHOLD)
            cur_thr = val;
        else
            cur_deb = val;
        cfg_writes++;
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(0, 7);
        write_cfg(CFG_THRESHOLD, (r == 0) ? 4095 : (r == 1) ? 1 : $urandom_range(1, 4095));
        r = $urandom_range(0, 7);
        write_cfg(CFG_DEBOUNCE, (r == 0) ? 0 : (r == 1) ? $urandom_range(8, 20)
                                                        : $urandom_range(1, 4));
    endtask

    // Mostly ticks, some misses, now and then a command the busy block should drop
    task automatic filler_word();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            put_word(REQ_TICK, 0, 0);
        end else if (r < 18) begin
            put_word(REQ_ADC, miss_value(), 0);
        end else begin
            busy_cmds_sent++;
            put_word((r == 18) ? REQ_CALIB : REQ_SETPOS, 0, $urandom_range(0, 127));
        end
    endtask

    // Close, open, close, open, close; a broken run stops partway
    task automatic calib_sequence(input bit complete);
        int ph;
        int k;
        int need;
        int steps;
        put_word(REQ_CALIB, 0, 0);
        for (ph = 0; ph < 5; ph++) begin
            steps = $urandom_range(0, 12);
            for (k = 0; k < steps; k++)
                filler_word();
            need = (cur_deb == 0) ? 1 : cur_deb;
            if (!complete)
                need = $urandom_range(0, need);
            for (k = 0; k < need; k++) begin
                if ($urandom_range(0, 5) == 0)
                    put_word(REQ_ADC, miss_value(), 0);
                put_word(REQ_ADC, hit_value(), 0);
            end
            if (!complete && $urandom_range(0, 2) == 0)
                return;
        end
    endtask

    task automatic seek_sequence();
        int pct;
        int steps;
        int k;
        pct = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
        put_word(REQ_SETPOS, 0, pct);
        steps = $urandom_range(0, 45);
        for (k = 0; k < steps; k++)
            filler_word();
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
            put_word(t_req'($urandom_range(0, 3)), $urandom_range(0, 4095),
                     $urandom_range(0, 127));
    endtask

    task automatic run_random(input int n_words);
        int stop_at;
        int pick;
        stop_at = words_sent - busy_cmds_sent + n_words;
        while (words_sent - busy_cmds_sent < stop_at) begin
            pick = $urandom_range(0, 11);
            if (pick < 4)
                calib_sequence(1'b1);
            else if (pick == 4)
                calib_sequence(1'b0);
            else if (pick < 9)
                seek_sequence();
            else if (pick < 11)
                noise_burst();
            else
                random_config();
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Idle events at reset settings, threshold edges, commands with zero max
        put_word(REQ_TICK, 0, 0);
        put_word(REQ_ADC, 4095, 0);
        put_word(REQ_ADC, 2024, 0);
        put_word(REQ_ADC, 2025, 0);
        put_word(REQ_SETPOS, 0, 0);
        put_word(REQ_SETPOS, 0, 127);
        write_cfg(CFG_THRESHOLD, 0);
        put_word(REQ_ADC, 0, 0);

        // Calibration with busy commands, max debounce, then debounce of zero
        write_cfg(CFG_THRESHOLD, 4095);
        write_cfg(CFG_DEBOUNCE, 255);
        put_word(REQ_CALIB, 0, 0);
        put_word(REQ_CALIB, 0, 0);
        put_word(REQ_SETPOS, 0, 50);
        put_word(REQ_TICK, 0, 0);
        put_word(REQ_ADC, 4095, 0);
        put_word(REQ_ADC, 0, 0);
        write_cfg(CFG_DEBOUNCE, 0);
        put_word(REQ_ADC, 4094, 0);
        repeat (2) put_word(REQ_TICK, 0, 0);
        put_word(REQ_ADC, 0, 0);
        put_word(REQ_TICK, 0, 0);
        put_word(REQ_ADC, 100, 0);
        repeat (3) put_word(REQ_TICK, 0, 0);
        put_word(REQ_ADC, 1, 0);
        put_word(REQ_ADC, 0, 0);
        put_word(REQ_SETPOS, 0, 100);
        repeat (2) put_word(REQ_TICK, 0, 0);

        // Random traffic under three pacing modes
        random_config();
        run_random(480);
        go_quiet();
        tx_idle_pct = 71;
        rx_idle_pct = 21;
        random_config();
        run_random(480);
        go_quiet();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(480);

        // Settle to idle, then a short calibration at a debounce of one
        // followed by a target above full open
        write_cfg(CFG_DEBOUNCE, 1);
        write_cfg(CFG_THRESHOLD, 2048);
        repeat (6) put_word(REQ_ADC, hit_value(), 0);
        repeat (150) put_word(REQ_TICK, 0, 0);
        repeat (6) put_word(REQ_ADC, hit_value(), 0);
        put_word(REQ_CALIB, 0, 0);
        put_word(REQ_ADC, hit_value(), 0);
        repeat (40) put_word(REQ_TICK, 0, 0);
        repeat (2) put_word(REQ_ADC, hit_value(), 0);
        repeat (30) put_word(REQ_TICK, 0, 0);
        repeat (2) put_word(REQ_ADC, hit_value(), 0);
        put_word(REQ_SETPOS, 0, 127);
        repeat (30) put_word(REQ_TICK, 0, 0);

        go_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Run: %0d words, %0d results checked, %0d calibrations done, %0d reg writes;",
                 words_sent, checked, calibs, cfg_writes);
        $display("three pacing modes, busy-command drops and a directed short calibration.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
